### rtl/core/sme_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the stack machine executor.
// No dependencies; used by every module of the block.
package sme_pkg;

    localparam int DATA_STACK_DEPTH_DEF = 64;
    localparam int CALL_STACK_DEPTH_DEF = 16;
    localparam int RAM_DEPTH_DEF        = 128;
    localparam int REG_COUNT_DEF        = 4;
    localparam int PC_WIDTH_DEF         = 16;

    localparam logic [6:0] MEM_TOP_RESET = 7'd100;

    localparam logic [4:0] OP_HALT    = 5'd0;
    localparam logic [4:0] OP_PUSH    = 5'd1;
    localparam logic [4:0] OP_IN      = 5'd2;
    localparam logic [4:0] OP_ADD     = 5'd3;
    localparam logic [4:0] OP_SUB     = 5'd4;
    localparam logic [4:0] OP_MUL     = 5'd5;
    localparam logic [4:0] OP_DIV     = 5'd6;
    localparam logic [4:0] OP_MOD     = 5'd7;
    localparam logic [4:0] OP_DISP    = 5'd8;
    localparam logic [4:0] OP_POP     = 5'd9;
    localparam logic [4:0] OP_OUT     = 5'd10;
    localparam logic [4:0] OP_SQUARE  = 5'd11;
    localparam logic [4:0] OP_SQRT    = 5'd12;
    localparam logic [4:0] OP_PUSHREG = 5'd13;
    localparam logic [4:0] OP_POPREG  = 5'd14;
    localparam logic [4:0] OP_JMP     = 5'd15;
    localparam logic [4:0] OP_JB      = 5'd16;
    localparam logic [4:0] OP_JAE     = 5'd17;
    localparam logic [4:0] OP_JA      = 5'd18;
    localparam logic [4:0] OP_JBE     = 5'd19;
    localparam logic [4:0] OP_JE      = 5'd20;
    localparam logic [4:0] OP_JNE     = 5'd21;
    localparam logic [4:0] OP_CALL    = 5'd22;
    localparam logic [4:0] OP_RET     = 5'd23;
    localparam logic [4:0] OP_PUSHM   = 5'd24;
    localparam logic [4:0] OP_POPM    = 5'd25;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_OP    = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd4;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd5;
    localparam logic [2:0] ST_NEG_ROOT  = 3'd6;
    localparam logic [2:0] ST_CALL_ERR  = 3'd7;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NUM  = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] operand;
        logic signed [31:0] in_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        next_ip;
        logic signed [31:0] out_value;
        logic [1:0]         out_kind;
        logic               halted;
        logic [2:0]         status;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic read;
        logic start;
        logic commit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_iter;
        logic iter_busy;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/core/sme_iter.sv
`timescale 1ns / 1ps
// Shared iterative unit: signed 32-bit divide/modulo (one bit a cycle)
// and floor square root (two bits a cycle). Uses sme_pkg.
module sme_iter
    import sme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        sqrt_mode,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        busy,
    output logic [31:0] quot,
    output logic [31:0] rem,
    output logic [31:0] root
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        mode_reg;
    logic        negq_reg, negr_reg;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [31:0] bit_reg, bit_next;
    logic [32:0] shifted;
    logic [31:0] trial;

    always_comb
    begin
        shifted  = {r_reg[31:0], q_reg[31]};
        trial    = r_reg[31:0] + bit_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!mode_reg)
            begin
                if (shifted >= {1'b0, d_reg})
                begin
                    r_next = shifted - {1'b0, d_reg};
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = shifted;
                    q_next = {q_reg[30:0], 1'b0};
                end
            end
            else
            begin
                // q holds the remainder of the radicand, r the root
                if (q_reg >= trial)
                begin
                    q_next = q_reg - trial;
                    r_next = {1'b0, (r_reg[31:0] >> 1) + bit_reg};
                end
                else
                begin
                    r_next = {1'b0, r_reg[31:0] >> 1};
                end
                bit_next = bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else if (start)
        begin
            cnt_reg <= sqrt_mode ? 6'd16 : 6'd32;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= sqrt_mode;
            negq_reg <= a[31] ^ b[31];
            negr_reg <= a[31];
            bit_reg  <= 32'h4000_0000;
            if (sqrt_mode)
            begin
                q_reg <= a;
                r_reg <= 33'd0;
            end
            else
            begin
                q_reg <= a[31] ? (32'd0 - a) : a;
                r_reg <= 33'd0;
            end
            d_reg <= b[31] ? (32'd0 - b) : b;
        end
        else
        begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            bit_reg <= bit_next;
        end
    end

    assign busy = (cnt_reg != 6'd0);
    assign quot = negq_reg ? (32'd0 - q_reg) : q_reg;
    assign rem  = negr_reg ? (32'd0 - r_reg[31:0]) : r_reg[31:0];
    assign root = r_reg[31:0];

endmodule

### rtl/core/sme_ctrl.sv
`timescale 1ns / 1ps
// Instruction sequencer: accept, stack read, execute, wait on the iterative unit.
// Uses sme_pkg.
module sme_ctrl
    import sme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.need_iter)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WAIT;
                end
                else if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (!stat.iter_busy && stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/sme_datapath.sv
`timescale 1ns / 1ps
// Datapath: stacks, registers, data memory, execute logic and result register.
// Uses sme_pkg and sme_iter.
module sme_datapath
    import sme_pkg::*;
#(
    parameter int DATA_STACK_DEPTH = DATA_STACK_DEPTH_DEF,
    parameter int CALL_STACK_DEPTH = CALL_STACK_DEPTH_DEF,
    parameter int RAM_DEPTH        = RAM_DEPTH_DEF,
    parameter int REG_COUNT        = REG_COUNT_DEF,
    parameter int PC_WIDTH         = PC_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output dp_stat_t  stat,
    input  in_item_t  in_data,
    input  logic      cfg_valid,
    input  logic [6:0] cfg_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int DW = $clog2(DATA_STACK_DEPTH + 1);
    localparam int DA = $clog2(DATA_STACK_DEPTH);
    localparam int CW = $clog2(CALL_STACK_DEPTH + 1);
    localparam int CA = $clog2(CALL_STACK_DEPTH);
    localparam int MA = $clog2(RAM_DEPTH);
    localparam int RI = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int PW = PC_WIDTH;

    localparam logic [DW-1:0] D_FULL = DW'(DATA_STACK_DEPTH);
    localparam logic [CW-1:0] C_FULL = CW'(CALL_STACK_DEPTH);

    // storage
    logic [31:0]   dstack [DATA_STACK_DEPTH];
    logic [PW-1:0] rstack [CALL_STACK_DEPTH];
    logic [31:0]   dmem   [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] dvalid_reg;
    logic [31:0]   gregs_reg [REG_COUNT];

    logic [DW-1:0] dcnt_reg;
    logic [CW-1:0] rcnt_reg;
    logic [PW-1:0] ip_reg;
    logic          halt_reg;
    logic [6:0]    mem_top_reg;

    in_item_t      item_reg;
    logic [31:0]   rd0_reg, rd1_reg;
    logic [PW-1:0] ret_reg;
    logic [31:0]   regv_reg;
    logic          addr_ok_reg;
    logic [31:0]   dm_rd_reg;
    logic          dm_vld_reg;

    logic          out_valid_reg;
    out_item_t     out_reg;

    // read-stage address logic
    logic [RI-1:0] ridx;
    logic [31:0]   regv;
    logic [MA-1:0] regv_addr;

    assign ridx      = item_reg.operand[RI-1:0];
    assign regv      = gregs_reg[ridx];
    assign regv_addr = regv[MA-1:0];

    // execute
    logic [4:0]    op;
    logic [31:0]   opnd;
    logic          reg_ok;
    logic [31:0]   x, y;
    logic [1:0]    npop;
    logic          uflow;
    logic [DW-1:0] cnt_after;
    logic          do_push;
    logic [31:0]   push_val;
    logic          ovf;
    logic [2:0]    st;
    logic [PW-1:0] nip, ip1, ip2, tgt;
    logic [31:0]   ov;
    logic [1:0]    kind;
    logic          set_halt;
    logic          greg_we, dmem_we, rs_push, rs_pop;
    logic          need_iter;
    logic          sqrt_op;
    logic          iter_busy;
    logic [31:0]   iq, ir, iroot;
    logic [31:0]   mul_a;
    logic [31:0]   prod;
    logic          out_free;
    logic [31:0]   nip_ext;

    assign op     = item_reg.command;
    assign opnd   = item_reg.operand;
    assign reg_ok = opnd < 32'(REG_COUNT);
    assign x      = (dcnt_reg != '0) ? rd0_reg : 32'd0;
    assign y      = (dcnt_reg >= DW'(2)) ? rd1_reg : 32'd0;
    assign ip1    = ip_reg + PW'(1);
    assign ip2    = ip_reg + PW'(2);
    assign tgt    = opnd[PW-1:0] + PW'(1);
    assign sqrt_op = (op == OP_SQRT);
    assign mul_a  = (op == OP_SQUARE) ? x : y;
    assign prod   = mul_a * x;

    always_comb
    begin
        npop     = 2'd0;
        do_push  = 1'b0;
        push_val = 32'd0;
        st       = ST_OK;
        nip      = ip1;
        ov       = 32'd0;
        kind     = KIND_NONE;
        set_halt = 1'b0;
        greg_we  = 1'b0;
        dmem_we  = 1'b0;
        rs_push  = 1'b0;
        rs_pop   = 1'b0;
        need_iter = 1'b0;
        unique case (op)
            OP_HALT: set_halt = 1'b1;
            OP_PUSH:
            begin
                do_push  = 1'b1;
                push_val = opnd;
                nip      = ip2;
            end
            OP_IN:
            begin
                do_push  = 1'b1;
                push_val = item_reg.in_value;
            end
            OP_ADD, OP_SUB, OP_MUL:
            begin
                npop    = 2'd2;
                do_push = 1'b1;
                unique case (op)
                    OP_ADD:  push_val = x + y;
                    OP_SUB:  push_val = y - x;
                    default: push_val = prod;
                endcase
            end
            OP_DIV, OP_MOD:
            begin
                npop    = 2'd2;
                do_push = 1'b1;
                if (x == 32'd0)
                begin
                    st = ST_DIV_ZERO;
                end
                else
                begin
                    need_iter = 1'b1;
                    push_val  = (op == OP_DIV) ? iq : ir;
                end
            end
            OP_DISP, OP_OUT:
            begin
                npop = 2'd1;
                ov   = x;
                kind = (op == OP_OUT) ? KIND_NUM : KIND_CHAR;
            end
            OP_POP: npop = 2'd1;
            OP_SQUARE:
            begin
                npop     = 2'd1;
                do_push  = 1'b1;
                push_val = prod;
            end
            OP_SQRT:
            begin
                npop    = 2'd1;
                do_push = 1'b1;
                if (x[31])
                begin
                    st = ST_NEG_ROOT;
                end
                else
                begin
                    need_iter = 1'b1;
                    push_val  = iroot;
                end
            end
            OP_PUSHREG:
            begin
                nip = ip2;
                if (!reg_ok)
                begin
                    st = ST_BAD_ADDR;
                end
                else
                begin
                    do_push  = 1'b1;
                    push_val = regv_reg;
                end
            end
            OP_POPREG:
            begin
                nip = ip2;
                if (!reg_ok)
                begin
                    st = ST_BAD_ADDR;
                end
                else
                begin
                    npop    = 2'd1;
                    greg_we = 1'b1;
                end
            end
            OP_JMP: nip = tgt;
            OP_JB, OP_JAE, OP_JA, OP_JBE, OP_JE, OP_JNE:
            begin
                logic take;
                npop = 2'd2;
                unique case (op)
                    OP_JB:   take = signed'(y) <  signed'(x);
                    OP_JAE:  take = signed'(y) >= signed'(x);
                    OP_JA:   take = signed'(y) >  signed'(x);
                    OP_JBE:  take = signed'(y) <= signed'(x);
                    OP_JE:   take = (x == y);
                    default: take = (x != y);
                endcase
                nip = take ? tgt : ip2;
            end
            OP_CALL:
            begin
                if (rcnt_reg >= C_FULL)
                begin
                    st  = ST_CALL_ERR;
                    nip = ip2;
                end
                else
                begin
                    rs_push = 1'b1;
                    nip     = opnd[PW-1:0];
                end
            end
            OP_RET:
            begin
                if (rcnt_reg == '0)
                begin
                    st = ST_CALL_ERR;
                end
                else
                begin
                    rs_pop = 1'b1;
                    nip    = ret_reg;
                end
            end
            OP_PUSHM, OP_POPM:
            begin
                nip = ip2;
                if (!reg_ok || !addr_ok_reg)
                begin
                    st = ST_BAD_ADDR;
                end
                else if (op == OP_PUSHM)
                begin
                    do_push  = 1'b1;
                    push_val = dm_vld_reg ? dm_rd_reg : 32'd0;
                end
                else
                begin
                    npop    = 2'd1;
                    dmem_we = 1'b1;
                end
            end
            default: st = ST_BAD_OP;
        endcase

        // a failed pop comes first, before any later fault of the same instruction
        uflow     = dcnt_reg < DW'(npop);
        cnt_after = uflow ? '0 : (dcnt_reg - DW'(npop));
        ovf       = do_push && (cnt_after == D_FULL);
        if (uflow)
        begin
            st = ST_UNDERFLOW;
        end
        else if (ovf && st == ST_OK)
        begin
            st = ST_OVERFLOW;
        end
        if (halt_reg)
        begin
            need_iter = 1'b0;
        end
    end

    sme_iter u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start),
        .sqrt_mode (sqrt_op),
        .a         (sqrt_op ? x : y),
        .b         (x),
        .busy      (iter_busy),
        .quot      (iq),
        .rem       (ir),
        .root      (iroot)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign stat.need_iter = need_iter;
    assign stat.iter_busy = iter_busy;
    assign stat.out_free  = out_free;

    // input latch and read stage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.read)
        begin
            rd0_reg     <= dstack[DA'(dcnt_reg - DW'(1))];
            rd1_reg     <= dstack[DA'(dcnt_reg - DW'(2))];
            ret_reg     <= rstack[CA'(rcnt_reg - CW'(1))];
            regv_reg    <= regv;
            addr_ok_reg <= (regv < 32'(RAM_DEPTH)) && (regv <= {25'd0, mem_top_reg});
            dm_rd_reg   <= dmem[regv_addr];
            dm_vld_reg  <= dvalid_reg[regv_addr];
        end
    end

    // memories written at commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !halt_reg)
        begin
            if (do_push && !ovf)
            begin
                dstack[cnt_after[DA-1:0]] <= push_val;
            end
            if (rs_push)
            begin
                rstack[rcnt_reg[CA-1:0]] <= ip2;
            end
            if (dmem_we)
            begin
                dmem[regv_reg[MA-1:0]] <= x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg    <= '0;
            rcnt_reg    <= '0;
            ip_reg      <= '0;
            halt_reg    <= 1'b0;
            dvalid_reg  <= '0;
            mem_top_reg <= MEM_TOP_RESET;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                gregs_reg[i] <= 32'd0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                mem_top_reg <= cfg_data;
            end
            if (cmd.commit && !halt_reg)
            begin
                dcnt_reg <= (do_push && !ovf) ? (cnt_after + DW'(1)) : cnt_after;
                if (rs_push)
                begin
                    rcnt_reg <= rcnt_reg + CW'(1);
                end
                else if (rs_pop)
                begin
                    rcnt_reg <= rcnt_reg - CW'(1);
                end
                ip_reg <= nip;
                if (set_halt)
                begin
                    halt_reg <= 1'b1;
                end
                if (greg_we)
                begin
                    gregs_reg[ridx] <= x;
                end
                if (dmem_we)
                begin
                    dvalid_reg[regv_reg[MA-1:0]] <= 1'b1;
                end
            end
        end
    end

    // result register
    assign nip_ext = 32'(halt_reg ? ip_reg : nip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.next_ip   <= nip_ext[15:0];
            out_reg.out_value <= halt_reg ? 32'd0 : ov;
            out_reg.out_kind  <= halt_reg ? KIND_NONE : kind;
            out_reg.halted    <= halt_reg | set_halt;
            out_reg.status    <= halt_reg ? ST_OK : st;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= D_FULL)
        else $error("data stack count out of range");

    a_rcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= C_FULL)
        else $error("call stack count out of range");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("result committed over an untaken result");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !iter_busy)
        else $error("iterative unit restarted while busy");

endmodule

### rtl/core/stack_machine_executor_top.sv
`timescale 1ns / 1ps
// Top level of the stack machine executor: sequencer plus datapath.
// Uses sme_pkg, sme_ctrl, sme_datapath.
// One instruction per input transfer, one result transfer per instruction. Most
// instructions pass through accept, stack/memory read and execute; div, mod and
// sqrt also wait on the shared one-bit-per-cycle divide / two-bit-per-cycle root
// unit. Execute holds until the output register is free. A new instruction is
// accepted while the previous result still waits in the output register.
// cfg_ready is always high; write mem_top only while idle.
module stack_machine_executor_top
    import sme_pkg::*;
#(
    parameter int DATA_STACK_DEPTH = DATA_STACK_DEPTH_DEF,
    parameter int CALL_STACK_DEPTH = CALL_STACK_DEPTH_DEF,
    parameter int RAM_DEPTH        = RAM_DEPTH_DEF,
    parameter int REG_COUNT        = REG_COUNT_DEF,
    parameter int PC_WIDTH         = PC_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    sme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sme_datapath #(
        .DATA_STACK_DEPTH (DATA_STACK_DEPTH),
        .CALL_STACK_DEPTH (CALL_STACK_DEPTH),
        .RAM_DEPTH        (RAM_DEPTH),
        .REG_COUNT        (REG_COUNT),
        .PC_WIDTH         (PC_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### verif/stack_machine_executor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the stack machine executor: a queue-fed driver, a result monitor
// and an instruction-level predictor. Depends on sme_pkg and stack_machine_executor_top.
module stack_machine_executor_top_tb;
    import sme_pkg::*;

    localparam int DSD = 64;
    localparam int CSD = 16;
    localparam int RAMD = 128;
    localparam int NREG = 4;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [6:0] cfg_data;

    stack_machine_executor_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] m_dstk [DSD];
    int          m_dcnt;
    logic [15:0] m_rstk [CSD];
    int          m_rcnt;
    logic [31:0] m_regs [NREG];
    logic [31:0] m_mem [RAMD];
    logic [15:0] m_ip;
    logic        m_halt;
    logic [6:0]  m_mem_top;
    logic [2:0]  m_st;

    in_item_t  instr_q [$];
    out_item_t expected_q [$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;

    // acceptance seen at the last rising edge
    logic in_ready_seen;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void flag_st(logic [2:0] c);
        if (m_st == ST_OK)
            m_st = c;
    endfunction

    function automatic logic [31:0] pop_d();
        if (m_dcnt == 0)
        begin
            flag_st(ST_UNDERFLOW);
            return 32'd0;
        end
        m_dcnt--;
        return m_dstk[m_dcnt];
    endfunction

    function automatic void push_d(logic [31:0] v);
        if (m_dcnt >= DSD)
        begin
            flag_st(ST_OVERFLOW);
            return;
        end
        m_dstk[m_dcnt] = v;
        m_dcnt++;
    endfunction

    function automatic logic [31:0] isqrt(logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic out_item_t execute_instr(in_item_t it);
        out_item_t o;
        logic [15:0] nip;
        logic [15:0] ip2;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] r;
        logic [31:0] a;
        logic take;
        logic [31:0] opnd;
        o = '0;
        opnd = it.operand;
        m_st = ST_OK;
        if (m_halt)
        begin
            o.next_ip = m_ip;
            o.halted = 1'b1;
            return o;
        end
        nip = m_ip + 16'd1;
        ip2 = m_ip + 16'd2;
        case (it.command)
            OP_HALT: m_halt = 1'b1;
            OP_PUSH:
            begin
                push_d(opnd);
                nip = ip2;
            end
            OP_IN: push_d(it.in_value);
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
            begin
                x = pop_d();
                y = pop_d();
                r = 0;
                if (it.command == OP_ADD)
                    r = x + y;
                else if (it.command == OP_SUB)
                    r = y - x;
                else if (it.command == OP_MUL)
                    r = x * y;
                else if (x == 0)
                    flag_st(ST_DIV_ZERO);
                else if (x == -1)
                    r = (it.command == OP_DIV) ? -y : 32'sd0;
                else
                    r = (it.command == OP_DIV) ? y / x : y % x;
                push_d(r);
            end
            OP_DISP, OP_OUT:
            begin
                o.out_value = pop_d();
                o.out_kind = (it.command == OP_OUT) ? KIND_NUM : KIND_CHAR;
            end
            OP_POP: x = pop_d();
            OP_SQUARE:
            begin
                x = pop_d();
                push_d(x * x);
            end
            OP_SQRT:
            begin
                x = pop_d();
                if (x[31])
                begin
                    flag_st(ST_NEG_ROOT);
                    push_d(32'd0);
                end
                else
                    push_d(isqrt(x));
            end
            OP_PUSHREG, OP_POPREG:
            begin
                nip = ip2;
                if (opnd >= NREG)
                    flag_st(ST_BAD_ADDR);
                else if (it.command == OP_PUSHREG)
                    push_d(m_regs[opnd]);
                else
                    m_regs[opnd] = pop_d();
            end
            OP_JMP: nip = opnd[15:0] + 16'd1;
            OP_JB, OP_JAE, OP_JA, OP_JBE, OP_JE, OP_JNE:
            begin
                x = pop_d();
                y = pop_d();
                case (it.command)
                    OP_JB:   take = y < x;
                    OP_JAE:  take = y >= x;
                    OP_JA:   take = y > x;
                    OP_JBE:  take = y <= x;
                    OP_JE:   take = y == x;
                    default: take = y != x;
                endcase
                nip = take ? opnd[15:0] + 16'd1 : ip2;
            end
            OP_CALL:
            begin
                if (m_rcnt >= CSD)
                begin
                    flag_st(ST_CALL_ERR);
                    nip = ip2;
                end
                else
                begin
                    m_rstk[m_rcnt] = ip2;
                    m_rcnt++;
                    nip = opnd[15:0];
                end
            end
            OP_RET:
            begin
                if (m_rcnt == 0)
                    flag_st(ST_CALL_ERR);
                else
                begin
                    m_rcnt--;
                    nip = m_rstk[m_rcnt];
                end
            end
            OP_PUSHM, OP_POPM:
            begin
                nip = ip2;
                if (opnd >= NREG)
                    flag_st(ST_BAD_ADDR);
                else
                begin
                    a = m_regs[opnd];
                    if (a > m_mem_top || a >= RAMD)
                        flag_st(ST_BAD_ADDR);
                    else if (it.command == OP_PUSHM)
                        push_d(m_mem[a]);
                    else
                        m_mem[a] = pop_d();
                end
            end
            default: flag_st(ST_BAD_OP);
        endcase
        m_ip = nip;
        o.next_ip = nip;
        o.halted = m_halt;
        o.status = m_st;
        return o;
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= instr_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
        begin
            in_ready_seen <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_q.push_back(execute_instr(in_data));
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_data.next_ip !== e.next_ip)
                begin
                    $error("next_ip exp %0h got %0h", e.next_ip, out_data.next_ip);
                    errors++;
                end
                if (out_data.out_value !== e.out_value)
                begin
                    $error("out_value exp %0h got %0h", e.out_value, out_data.out_value);
                    errors++;
                end
                if (out_data.out_kind !== e.out_kind)
                begin
                    $error("out_kind exp %0d got %0d", e.out_kind, out_data.out_kind);
                    errors++;
                end
                if (out_data.halted !== e.halted)
                begin
                    $error("halted exp %0d got %0d", e.halted, out_data.halted);
                    errors++;
                end
                if (out_data.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    function automatic in_item_t mk(logic [4:0] c, logic [31:0] o, logic [31:0] v);
        in_item_t it;
        it.command = c;
        it.operand = o;
        it.in_value = v;
        return it;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return $urandom_range(3);
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    // one random instruction, mostly legal and shaped so the stack stays busy
    function automatic in_item_t rnd_instr();
        logic [4:0] c;
        logic [31:0] o;
        int k;
        k = $urandom_range(99);
        if (k < 3)
            c = 5'(26 + $urandom_range(5));
        else if (k < 30)
            c = ($urandom_range(1) != 0) ? OP_PUSH : OP_IN;
        else
            c = 5'($urandom_range(25));
        if (c == OP_HALT)
            c = OP_PUSH;
        if (c inside {OP_PUSHREG, OP_POPREG, OP_PUSHM, OP_POPM})
            o = ($urandom_range(9) == 0) ? rnd_word() : $urandom_range(NREG - 1);
        else
            o = rnd_word();
        return mk(c, o, rnd_word());
    endfunction

    task automatic wait_drained();
        while (instr_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_mem_top(logic [6:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        m_mem_top = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // a halt is final until reset, so random programs never halt; the halt goes last
    initial
    begin
        int n;
        int p;
        logic [6:0] tops [4];
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_dcnt = 0;
        m_rcnt = 0;
        m_ip = '0;
        m_halt = 1'b0;
        m_mem_top = MEM_TOP_RESET;
        foreach (m_regs[i]) m_regs[i] = '0;
        foreach (m_mem[i]) m_mem[i] = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corner cases for a selection of opcodes, plus an illegal opcode
        instr_q.push_back(mk(OP_POP, 0, 0));
        instr_q.push_back(mk(OP_RET, 0, 0));
        instr_q.push_back(mk(OP_PUSH, 32'h8000_0000, 0));
        instr_q.push_back(mk(OP_IN, 0, 32'hffff_ffff));
        instr_q.push_back(mk(OP_DIV, 0, 0));
        instr_q.push_back(mk(OP_PUSH, 32'h8000_0000, 0));
        instr_q.push_back(mk(OP_PUSH, 32'hffff_ffff, 0));
        instr_q.push_back(mk(OP_MOD, 0, 0));
        instr_q.push_back(mk(OP_PUSH, 0, 0));
        instr_q.push_back(mk(OP_MOD, 0, 0));
        instr_q.push_back(mk(OP_PUSH, 32'h7fff_ffff, 0));
        instr_q.push_back(mk(OP_SQRT, 0, 0));
        instr_q.push_back(mk(OP_PUSH, 32'hffff_fff0, 0));
        instr_q.push_back(mk(OP_SQRT, 0, 0));
        instr_q.push_back(mk(OP_OUT, 0, 0));
        instr_q.push_back(mk(OP_DISP, 0, 0));
        instr_q.push_back(mk(OP_PUSHREG, 7, 0));
        instr_q.push_back(mk(OP_PUSH, 100, 0));
        instr_q.push_back(mk(OP_POPREG, 3, 0));
        instr_q.push_back(mk(OP_POPM, 3, 0));
        instr_q.push_back(mk(OP_PUSHM, 3, 0));
        instr_q.push_back(mk(OP_CALL, 32'h0000_fffe, 0));
        instr_q.push_back(mk(OP_RET, 0, 0));
        instr_q.push_back(mk(OP_JE, 32'hffff_ffff, 0));
        instr_q.push_back(mk(5'd31, 0, 0));
        wait_drained();

        tops[0] = 7'd0;
        tops[1] = 7'd127;
        tops[2] = 7'd5;
        tops[3] = 7'd100;
        for (p = 0; p < 8; p++)
        begin
            write_mem_top(tops[p % 4]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (n = 0; n < 200; n++)
            begin
                if (p == 2 && n == 100)
                    wait_drained();
                if (p == 3 && n == 0)
                    // fill the call stack and overflow it
                    repeat (18) instr_q.push_back(mk(OP_CALL, rnd_word(), 0));
                if (p == 5 && n == 0)
                    repeat (66) instr_q.push_back(mk(OP_PUSH, rnd_word(), 0));
                instr_q.push_back(rnd_instr());
            end
            wait_drained();
        end
        instr_q.push_back(mk(OP_HALT, 0, 0));
        instr_q.push_back(mk(OP_PUSH, 1, 0));
        wait_drained();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
